@@ hdl/lbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbp_pkg
// Types, codes and fixed-point constants shared by the layer blend pipeline.
// ----------------------------------------------------------------------------
package lbp_pkg;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pixel_out_t;

    typedef struct packed {
        logic advance;
    } lane_ctrl_t;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPACITY    = 1'd1;

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY   = 3'd1;
    localparam logic [2:0] MODE_SCREEN     = 3'd2;
    localparam logic [2:0] MODE_OVERLAY    = 3'd3;
    localparam logic [2:0] MODE_ADD        = 3'd4;
    localparam logic [2:0] MODE_SUBTRACT   = 3'd5;
    localparam logic [2:0] MODE_DIFFERENCE = 3'd6;

    localparam logic [7:0]  OPACITY_RESET = 8'd255;
    localparam logic [7:0]  BYTE_MAX      = 8'd255;
    localparam logic [15:0] UNIT2         = 16'd65025;

    // Color channel: quotient of (2N + 255*65025) by 510*65025.
    localparam logic [32:0] CH_ROUND = 33'd16581375;
    localparam logic [24:0] CH_DIV   = 25'd33162750;
    localparam logic [16:0] CH_RECIP = 17'd66310;

    // Alpha channel: quotient of (2P + 65025) by 2*65025.
    localparam logic [24:0] AL_ROUND = 25'd65025;
    localparam logic [16:0] AL_DIV   = 17'd130050;
    localparam logic [16:0] AL_RECIP = 17'd66051;

    function automatic logic [15:0] times_255(input logic [7:0] v);
        times_255 = {v, 8'd0} - {8'd0, v};
    endfunction

endpackage

@@ hdl/layer_blend_pixel.sv @@
// ----------------------------------------------------------------------------
// layer_blend_pixel
// Composites a source RGBA pixel onto a destination pixel with a selectable
// blend mode and layer opacity. One pixel transfer is taken per clock while the
// input is not stalled, and it passes through the five-stage lane pipeline (blend
// and alpha products, the two mixing multiplies, the sum, the reciprocal
// estimate and the final correction). Three color lanes and one alpha lane run
// side by side. A stall on the result side while a result is valid freezes the
// whole pipeline, and a one-entry skid buffer keeps the input stall registered.
// ----------------------------------------------------------------------------
module layer_blend_pixel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  lbp_pkg::pixel_in_t                  pix_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output lbp_pkg::pixel_out_t                 res_data,
    input  logic                                cfg_we,
    input  logic [lbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned DEPTH = 5;

    logic [2:0]           mode_reg;
    logic [7:0]           opacity_reg;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    lbp_pkg::pixel_in_t   skid_data_reg;
    logic [DEPTH-1:0]     stage_valid_reg;
    logic [DEPTH-1:0]     stage_valid_next;

    logic                 en;
    logic                 accept;
    logic                 feed_valid;
    lbp_pkg::pixel_in_t   feed;
    logic [15:0]          alpha_eff;
    lbp_pkg::lane_ctrl_t  ctrl;

    logic [7:0]           red_q;
    logic [7:0]           green_q;
    logic [7:0]           blue_q;
    logic [7:0]           alpha_q;

    assign en         = !(stage_valid_reg[DEPTH-1] && res_stall);
    assign pix_stall  = skid_valid_reg;
    assign accept     = pix_valid && !pix_stall;
    assign feed       = skid_valid_reg ? skid_data_reg : pix_data;
    assign feed_valid = skid_valid_reg || pix_valid;
    assign alpha_eff  = 16'(feed.src_alpha) * 16'(opacity_reg);
    assign ctrl.advance = en;

    always_comb
    begin
        skid_valid_next  = skid_valid_reg;
        stage_valid_next = stage_valid_reg;
        if (en)
        begin
            skid_valid_next  = 1'b0;
            stage_valid_next = {stage_valid_reg[DEPTH-2:0], feed_valid};
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= lbp_pkg::MODE_NORMAL;
            opacity_reg     <= lbp_pkg::OPACITY_RESET;
            skid_valid_reg  <= 1'b0;
            stage_valid_reg <= '0;
        end
        else
        begin
            skid_valid_reg  <= skid_valid_next;
            stage_valid_reg <= stage_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lbp_pkg::CFG_BLEND_MODE:
                    begin
                        mode_reg <= cfg_data[2:0];
                    end
                    lbp_pkg::CFG_OPACITY:
                    begin
                        opacity_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && accept)
        begin
            skid_data_reg <= pix_data;
        end
    end

    lbp_lane u_lane_red (
        .clk       (clk),
        .ctrl      (ctrl),
        .mode      (mode_reg),
        .base      (feed.dst_red),
        .blend     (feed.src_red),
        .alpha_eff (alpha_eff),
        .result    (red_q)
    );

    lbp_lane u_lane_green (
        .clk       (clk),
        .ctrl      (ctrl),
        .mode      (mode_reg),
        .base      (feed.dst_green),
        .blend     (feed.src_green),
        .alpha_eff (alpha_eff),
        .result    (green_q)
    );

    lbp_lane u_lane_blue (
        .clk       (clk),
        .ctrl      (ctrl),
        .mode      (mode_reg),
        .base      (feed.dst_blue),
        .blend     (feed.src_blue),
        .alpha_eff (alpha_eff),
        .result    (blue_q)
    );

    lbp_alpha u_alpha (
        .clk       (clk),
        .ctrl      (ctrl),
        .dst_alpha (feed.dst_alpha),
        .alpha_eff (alpha_eff),
        .result    (alpha_q)
    );

    assign res_valid          = stage_valid_reg[DEPTH-1];
    assign res_data.out_red   = red_q;
    assign res_data.out_green = green_q;
    assign res_data.out_blue  = blue_q;
    assign res_data.out_alpha = alpha_q;

    // The skid buffer only fills while the result side holds the pipeline.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(res_valid && res_stall))
        else $error("skid buffer filled without a stalled result");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (stage_valid_reg[DEPTH-1:1] == $past(stage_valid_reg[DEPTH-2:0])))
        else $error("pipeline valid bits did not shift on advance");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_valid_reg))
        else $error("pipeline valid bits changed while frozen");

endmodule

@@ hdl/lbp_lane.sv @@
// ----------------------------------------------------------------------------
// lbp_lane
// One color channel: blend mode, alpha mix and rounded constant division.
// ----------------------------------------------------------------------------
module lbp_lane (
    input  logic              clk,
    input  lbp_pkg::lane_ctrl_t ctrl,
    input  logic [2:0]        mode,
    input  logic [7:0]        base,
    input  logic [7:0]        blend,
    input  logic [15:0]       alpha_eff,
    output logic [7:0]        result
);

    logic [7:0]  base_inv;
    logic [7:0]  blend_inv;
    logic [15:0] prod_direct;
    logic [15:0] prod_inverse;
    logic [8:0]  sum_bytes;
    logic [7:0]  delta;
    logic [15:0] mix_next;

    logic [15:0] alpha_reg;
    logic [15:0] keep_reg;
    logic [15:0] base_scaled_reg;
    logic [15:0] mix_reg;

    logic [31:0] keep_part_reg;
    logic [31:0] mix_part_reg;

    logic [32:0] sum_parts;
    logic [32:0] num_next;
    logic [32:0] num_reg;

    logic [32:0] est_prod;
    logic [7:0]  est_reg;
    logic [32:0] num_late_reg;

    logic [8:0]  est_up;
    logic [33:0] thresh;
    logic [7:0]  quot_next;
    logic [7:0]  result_reg;

    assign base_inv     = lbp_pkg::BYTE_MAX - base;
    assign blend_inv    = lbp_pkg::BYTE_MAX - blend;
    assign prod_direct  = 16'(base) * 16'(blend);
    assign prod_inverse = 16'(base_inv) * 16'(blend_inv);
    assign sum_bytes    = {1'b0, base} + {1'b0, blend};
    assign delta        = (base > blend) ? (base - blend) : (blend - base);

    always_comb
    begin
        unique case (mode)
            lbp_pkg::MODE_MULTIPLY:
            begin
                mix_next = prod_direct;
            end
            lbp_pkg::MODE_SCREEN:
            begin
                mix_next = lbp_pkg::UNIT2 - prod_inverse;
            end
            lbp_pkg::MODE_OVERLAY:
            begin
                if (!base[7])
                begin
                    mix_next = 16'({prod_direct, 1'b0});
                end
                else
                begin
                    mix_next = lbp_pkg::UNIT2 - 16'({prod_inverse, 1'b0});
                end
            end
            lbp_pkg::MODE_ADD:
            begin
                mix_next = (sum_bytes >= 9'd255) ? lbp_pkg::UNIT2
                                                 : lbp_pkg::times_255(sum_bytes[7:0]);
            end
            lbp_pkg::MODE_SUBTRACT:
            begin
                mix_next = (base > blend) ? lbp_pkg::times_255(delta) : 16'd0;
            end
            lbp_pkg::MODE_DIFFERENCE:
            begin
                mix_next = lbp_pkg::times_255(delta);
            end
            default:
            begin
                mix_next = lbp_pkg::times_255(blend);
            end
        endcase
    end

    assign sum_parts = 33'(keep_part_reg) + 33'(mix_part_reg);
    assign num_next  = {sum_parts[31:0], 1'b0} + lbp_pkg::CH_ROUND;
    assign est_prod  = 33'(num_reg[32:17]) * 33'(lbp_pkg::CH_RECIP);

    // The estimate is never above the true quotient and at most one below it.
    assign est_up    = {1'b0, est_reg} + 9'd1;
    assign thresh    = 34'(est_up) * 34'(lbp_pkg::CH_DIV);
    assign quot_next = ({1'b0, num_late_reg} >= thresh) ? est_up[7:0] : est_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            alpha_reg       <= alpha_eff;
            keep_reg        <= lbp_pkg::UNIT2 - alpha_eff;
            base_scaled_reg <= lbp_pkg::times_255(base);
            mix_reg         <= mix_next;
            keep_part_reg   <= base_scaled_reg * keep_reg;
            mix_part_reg    <= mix_reg * alpha_reg;
            num_reg         <= num_next;
            est_reg         <= est_prod[31:24];
            num_late_reg    <= num_reg;
            result_reg      <= quot_next;
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/lbp_alpha.sv @@
// ----------------------------------------------------------------------------
// lbp_alpha
// Alpha channel: source-over combination with rounded constant division.
// ----------------------------------------------------------------------------
module lbp_alpha (
    input  logic              clk,
    input  lbp_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]        dst_alpha,
    input  logic [15:0]       alpha_eff,
    output logic [7:0]        result
);

    logic [15:0] alpha_reg;
    logic [7:0]  inv_reg;
    logic [7:0]  dst1_reg;
    logic [7:0]  dst2_reg;
    logic [7:0]  dst3_reg;
    logic [7:0]  dst4_reg;
    logic [23:0] part_reg;
    logic [24:0] num_reg;
    logic [24:0] num_late_reg;
    logic [7:0]  est_reg;

    logic [32:0] est_prod;
    logic [8:0]  est_up;
    logic [25:0] thresh;
    logic [7:0]  quot;
    logic [8:0]  total;
    logic [7:0]  result_reg;

    assign est_prod = 33'(num_reg[24:9]) * 33'(lbp_pkg::AL_RECIP);
    assign est_up   = {1'b0, est_reg} + 9'd1;
    assign thresh   = 26'(est_up) * 26'(lbp_pkg::AL_DIV);
    assign quot     = ({1'b0, num_late_reg} >= thresh) ? est_up[7:0] : est_reg;
    assign total    = {1'b0, dst4_reg} + {1'b0, quot};

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            alpha_reg    <= alpha_eff;
            inv_reg      <= lbp_pkg::BYTE_MAX - dst_alpha;
            dst1_reg     <= dst_alpha;
            part_reg     <= 24'(alpha_reg) * 24'(inv_reg);
            dst2_reg     <= dst1_reg;
            num_reg      <= {part_reg, 1'b0} + lbp_pkg::AL_ROUND;
            dst3_reg     <= dst2_reg;
            est_reg      <= est_prod[31:24];
            num_late_reg <= num_reg;
            dst4_reg     <= dst3_reg;
            result_reg   <= total[8] ? lbp_pkg::BYTE_MAX : total[7:0];
        end
    end

    assign result = result_reg;

endmodule
